@@ rtl/oal_pkg.sv @@
// Package for the ordered array list engine.
// Holds the operation, status, cell-command and state types shared by the cell and the top level.
// No dependencies.
package oal_pkg;

    localparam int DepthDefault     = 64;
    localparam int WordWidthDefault = 32;
    localparam int CapReset         = 64;
    localparam int PosW             = 10;

    typedef enum logic [3:0] {
        FN_APPEND     = 4'd0,
        FN_INSERT     = 4'd1,
        FN_REPLACE    = 4'd2,
        FN_SWAP       = 4'd3,
        FN_READ       = 4'd4,
        FN_READ_LAST  = 4'd5,
        FN_FIND       = 4'd6,
        FN_REMOVE_VAL = 4'd7,
        FN_REMOVE_AT  = 4'd8,
        FN_POP        = 4'd9,
        FN_CLEAR      = 4'd10
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_RANGE    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CM_HOLD,
        CM_INSERT,
        CM_WRITE,
        CM_SWAP,
        CM_REMOVE
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t        mode;
        logic [PosW-1:0]   pos_a;
        logic [PosW-1:0]   pos_b;
    } cell_ctl_t;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } ctl_state_t;

endpackage

@@ rtl/oal_cell.sv @@
// One storage cell of the list: holds one entry word and its registered match flag.
// Takes words from its left or right neighbor on shifts. Depends on oal_pkg.
module oal_cell #(
    parameter int POS        = 0,
    parameter int WORD_WIDTH = oal_pkg::WordWidthDefault,
    parameter int CNT_W      = $clog2(oal_pkg::DepthDefault + 1)
) (
    input  logic                  clk,
    input  oal_pkg::cell_ctl_t    ctl,
    input  logic [WORD_WIDTH-1:0] elem,
    input  logic [WORD_WIDTH-1:0] word_a,
    input  logic [WORD_WIDTH-1:0] word_b,
    input  logic [WORD_WIDTH-1:0] left_word,
    input  logic [WORD_WIDTH-1:0] right_word,
    input  logic                  cmp_en,
    input  logic [WORD_WIDTH-1:0] cmp_elem,
    input  logic [CNT_W-1:0]      count,
    output logic [WORD_WIDTH-1:0] word,
    output logic                  match
);
    import oal_pkg::*;

    localparam logic [PosW-1:0]  MyPos    = PosW'(POS);
    localparam logic [CNT_W-1:0] MyPosCnt = CNT_W'(POS);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;
    logic                  match_reg;
    logic                  match_next;

    always_comb
    begin
        word_next = word_reg;
        case (ctl.mode)
            CM_INSERT:
            begin
                if (MyPos == ctl.pos_a)
                    word_next = elem;
                else if (MyPos > ctl.pos_a)
                    word_next = left_word;
            end
            CM_WRITE:
            begin
                if (MyPos == ctl.pos_a)
                    word_next = elem;
            end
            CM_SWAP:
            begin
                if (MyPos == ctl.pos_a)
                    word_next = word_b;
                else if (MyPos == ctl.pos_b)
                    word_next = word_a;
            end
            CM_REMOVE:
            begin
                if (MyPos >= ctl.pos_a)
                    word_next = right_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_comb
    begin
        match_next = match_reg;
        if (cmp_en)
            match_next = (word_reg == cmp_elem) && (MyPosCnt < count);
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        match_reg <= match_next;
    end

    assign word  = word_reg;
    assign match = match_reg;

endmodule

@@ rtl/ordered_array_list_engine_core.sv @@
// Ordered array list engine: a row of DEPTH cells holding the list, shifting on insert and remove.
// Each accepted item is captured (cell compare and word reads) while idle, then applied to the cell row
// in the apply state, which loads the result register; no new item is taken until the apply is done.
// A stalled output holds the apply state until the result register is free.
// Reset: count 0, capacity limit 64 (clamped to DEPTH); entry words are not reset.
// Depends on oal_pkg and oal_cell.
module ordered_array_list_engine_core #(
    parameter int DEPTH      = oal_pkg::DepthDefault,
    parameter int WORD_WIDTH = oal_pkg::WordWidthDefault,
    parameter int IDX_W      = $clog2(DEPTH),
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            func,
    input  logic [WORD_WIDTH-1:0] element,
    input  logic [IDX_W-1:0]      index,
    input  logic [IDX_W-1:0]      second_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [WORD_WIDTH-1:0] value,
    output logic [IDX_W-1:0]      found_index,
    output logic [CNT_W-1:0]      count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNT_W-1:0]      cfg_data
);
    import oal_pkg::*;

    localparam int CapRst = (CapReset < DEPTH) ? CapReset : DEPTH;

    ctl_state_t            state_reg;
    ctl_state_t            state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      cap_reg;
    logic [CNT_W-1:0]      cap_next;

    logic [3:0]            func_reg;
    logic [WORD_WIDTH-1:0] elem_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx2_reg;
    logic [WORD_WIDTH-1:0] rd_a_reg;
    logic [WORD_WIDTH-1:0] rd_b_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [1:0]            status_reg;
    logic [WORD_WIDTH-1:0] value_reg;
    logic [IDX_W-1:0]      found_reg;
    logic [CNT_W-1:0]      count_out_reg;

    logic [WORD_WIDTH-1:0] words_w [DEPTH];
    logic [DEPTH-1:0]      match_w;

    logic                  in_xfer;
    logic                  load;
    logic [IDX_W-1:0]      rd_addr_a;
    logic [CNT_W-1:0]      count_m1;

    cell_ctl_t             cmd;
    cell_ctl_t             cell_ctl;
    status_t               res_status;
    logic [WORD_WIDTH-1:0] res_value;
    logic [IDX_W-1:0]      res_found;
    logic [CNT_W-1:0]      res_count;
    logic [IDX_W-1:0]      hit_idx;
    logic                  hit_any;
    logic [CNT_W-1:0]      lim;
    logic                  is_full;
    logic                  a_out;
    logic                  b_out;

    // Cell row
    genvar k;
    generate
        for (k = 0; k < DEPTH; k++)
        begin : g_cell
            logic [WORD_WIDTH-1:0] left_w;
            logic [WORD_WIDTH-1:0] right_w;
            if (k == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = words_w[k-1];
            end
            if (k == DEPTH - 1)
            begin : g_last
                assign right_w = words_w[k];
            end
            else
            begin : g_mid_r
                assign right_w = words_w[k+1];
            end
            oal_cell #(
                .POS        (k),
                .WORD_WIDTH (WORD_WIDTH),
                .CNT_W      (CNT_W)
            ) u_cell (
                .clk        (clk),
                .ctl        (cell_ctl),
                .elem       (elem_reg),
                .word_a     (rd_a_reg),
                .word_b     (rd_b_reg),
                .left_word  (left_w),
                .right_word (right_w),
                .cmp_en     (in_xfer),
                .cmp_elem   (element),
                .count      (count_reg),
                .word       (words_w[k]),
                .match      (match_w[k])
            );
        end
    endgenerate

    // Capture
    assign in_xfer  = in_valid && in_ready;
    assign count_m1 = count_reg - CNT_W'(1);
    assign rd_addr_a = (func_t'(func) == FN_READ_LAST || func_t'(func) == FN_POP)
                       ? count_m1[IDX_W-1:0] : index;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg <= func;
            elem_reg <= element;
            idx_reg  <= index;
            idx2_reg <= second_index;
            rd_a_reg <= words_w[rd_addr_a];
            rd_b_reg <= words_w[second_index];
        end
    end

    // First match
    always_comb
    begin
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_w[i])
            begin
                hit_idx = IDX_W'(i);
                hit_any = 1'b1;
            end
        end
    end

    // Apply
    assign lim     = (cap_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;
    assign is_full = count_reg >= lim;
    assign a_out   = CNT_W'(idx_reg) >= count_reg;
    assign b_out   = CNT_W'(idx2_reg) >= count_reg;

    always_comb
    begin
        res_status = STAT_OK;
        res_value  = '0;
        res_found  = '0;
        res_count  = count_reg;
        cmd.mode   = CM_HOLD;
        cmd.pos_a  = PosW'(idx_reg);
        cmd.pos_b  = PosW'(idx2_reg);
        case (func_t'(func_reg))
            FN_APPEND:
            begin
                if (is_full)
                    res_status = STAT_FULL;
                else
                begin
                    cmd.mode  = CM_INSERT;
                    cmd.pos_a = PosW'(count_reg);
                    res_count = count_reg + CNT_W'(1);
                end
            end
            FN_INSERT:
            begin
                if (CNT_W'(idx_reg) > count_reg)
                    res_status = STAT_RANGE;
                else if (is_full)
                    res_status = STAT_FULL;
                else
                begin
                    cmd.mode  = CM_INSERT;
                    res_count = count_reg + CNT_W'(1);
                end
            end
            FN_REPLACE:
            begin
                if (a_out)
                    res_status = STAT_RANGE;
                else
                begin
                    res_value = rd_a_reg;
                    cmd.mode  = CM_WRITE;
                end
            end
            FN_SWAP:
            begin
                if (a_out || b_out)
                    res_status = STAT_RANGE;
                else
                    cmd.mode = CM_SWAP;
            end
            FN_READ:
            begin
                if (a_out)
                    res_status = STAT_RANGE;
                else
                    res_value = rd_a_reg;
            end
            FN_REMOVE_AT:
            begin
                if (a_out)
                    res_status = STAT_RANGE;
                else
                begin
                    res_value = rd_a_reg;
                    cmd.mode  = CM_REMOVE;
                    res_count = count_m1;
                end
            end
            FN_READ_LAST:
            begin
                if (count_reg == '0)
                    res_status = STAT_RANGE;
                else
                    res_value = rd_a_reg;
            end
            FN_POP:
            begin
                if (count_reg == '0)
                    res_status = STAT_RANGE;
                else
                begin
                    res_value = rd_a_reg;
                    res_count = count_m1;
                end
            end
            FN_FIND:
            begin
                if (hit_any)
                    res_found = hit_idx;
                else
                    res_status = STAT_NOTFOUND;
            end
            FN_REMOVE_VAL:
            begin
                if (hit_any)
                begin
                    res_found = hit_idx;
                    res_value = elem_reg;
                    cmd.mode  = CM_REMOVE;
                    cmd.pos_a = PosW'(hit_idx);
                    res_count = count_m1;
                end
                else
                    res_status = STAT_NOTFOUND;
            end
            FN_CLEAR:
            begin
                res_count = '0;
            end
            default:
            begin
                res_status = STAT_OK;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready = 1'b0;
        load     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_APPLY:
            begin
                load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cell_ctl = cmd;
        if (!load)
            cell_ctl.mode = CM_HOLD;
    end

    assign count_next     = load ? res_count : count_reg;
    assign cap_next       = (cfg_valid && cfg_ready) ? cfg_data : cap_reg;
    assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign cfg_ready      = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CNT_W'(CapRst);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg    <= res_status;
            value_reg     <= res_value;
            found_reg     <= res_found;
            count_out_reg <= res_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign value       = value_reg;
    assign found_index = found_reg;
    assign count       = count_out_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_accept_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == S_APPLY))
        else $error("transfer not followed by apply");

    a_count_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(count_reg))
        else $error("count changed without a result load");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_valid_reg && count == count_reg))
        else $error("result count disagrees with list count");
`endif

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for ordered_array_list_engine_core: directed table, then random phases.
// Expected results come from typed table rows or an in-bench model of the list and its capacity.
// Depends on oal_pkg and the RTL of ordered_array_list_engine_core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import oal_pkg::*;

    localparam int DEPTH = DepthDefault;
    localparam int DIR_ROWS = 25;
    localparam int PHASES = 8;
    localparam logic [3:0] FN_UNUSED_LO = 4'd11;
    localparam logic [3:0] FN_UNUSED_HI = 4'd15;

    typedef struct packed {
        status_t     status;
        logic [31:0] value;
        logic [5:0]  found_index;
        logic [6:0]  count;
    } result_t;

    typedef struct packed {
        logic [3:0]  f;
        logic [31:0] e;
        logic [5:0]  i;
        logic [5:0]  j;
        logic        typed;
        result_t     res;
    } row_t;

    localparam result_t UNTYPED = '{STAT_OK, 32'h0, 6'd0, 7'd0};

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  func = 4'd0;
    logic [31:0] element = 32'h0;
    logic [5:0]  index = 6'd0;
    logic [5:0]  second_index = 6'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [31:0] value;
    logic [5:0]  found_index;
    logic [6:0]  count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = 7'd0;

    logic [31:0] list_words [DEPTH];
    int          list_count = 0;
    int          cap_limit = CapReset;
    result_t     pending_results [$];
    int          mismatch_count = 0;
    int          result_seq = 0;
    bit          steady = 1'b0;

    row_t dir_rows [DIR_ROWS] = '{
        '{FN_READ_LAST,  32'h0,        6'd0,  6'd0,  1'b1, '{STAT_RANGE, 32'h0, 6'd0, 7'd0}},
        '{FN_POP,        32'h0,        6'd0,  6'd0,  1'b1, '{STAT_RANGE, 32'h0, 6'd0, 7'd0}},
        '{FN_READ,       32'h0,        6'd0,  6'd0,  1'b1, '{STAT_RANGE, 32'h0, 6'd0, 7'd0}},
        '{FN_FIND,       32'h0,        6'd0,  6'd0,  1'b1,
          '{STAT_NOTFOUND, 32'h0, 6'd0, 7'd0}},
        '{FN_APPEND,     32'hFFFFFFFF, 6'd0,  6'd0,  1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd1}},
        '{FN_APPEND,     32'h0,        6'd0,  6'd0,  1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd2}},
        '{FN_INSERT,     32'h12345678, 6'd2,  6'd0,  1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd3}},
        '{FN_INSERT,     32'h00000001, 6'd5,  6'd0,  1'b1, '{STAT_RANGE, 32'h0, 6'd0, 7'd3}},
        '{FN_INSERT,     32'hA5A5A5A5, 6'd0,  6'd0,  1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd4}},
        '{FN_REPLACE,    32'h5A5A5A5A, 6'd1,  6'd0,  1'b0, UNTYPED},
        '{FN_REPLACE,    32'h0,        6'd63, 6'd0,  1'b1, '{STAT_RANGE, 32'h0, 6'd0, 7'd4}},
        '{FN_SWAP,       32'h0,        6'd0,  6'd3,  1'b0, UNTYPED},
        '{FN_SWAP,       32'h0,        6'd3,  6'd63, 1'b1, '{STAT_RANGE, 32'h0, 6'd0, 7'd4}},
        '{FN_READ,       32'h0,        6'd2,  6'd0,  1'b0, UNTYPED},
        '{FN_FIND,       32'h12345678, 6'd0,  6'd0,  1'b0, UNTYPED},
        '{FN_REMOVE_VAL, 32'hDEADBEEF, 6'd0,  6'd0,  1'b1,
          '{STAT_NOTFOUND, 32'h0, 6'd0, 7'd4}},
        '{FN_REMOVE_VAL, 32'h5A5A5A5A, 6'd0,  6'd0,  1'b0, UNTYPED},
        '{FN_REMOVE_AT,  32'h0,        6'd63, 6'd0,  1'b1, '{STAT_RANGE, 32'h0, 6'd0, 7'd3}},
        '{FN_REMOVE_AT,  32'h0,        6'd0,  6'd0,  1'b0, UNTYPED},
        '{FN_READ_LAST,  32'h0,        6'd0,  6'd0,  1'b0, UNTYPED},
        '{FN_UNUSED_HI,  32'hFFFFFFFF, 6'd63, 6'd63, 1'b0, UNTYPED},
        '{FN_UNUSED_LO,  32'h0,        6'd0,  6'd0,  1'b0, UNTYPED},
        '{FN_POP,        32'h0,        6'd0,  6'd0,  1'b0, UNTYPED},
        '{FN_CLEAR,      32'h0,        6'd0,  6'd0,  1'b1, '{STAT_OK, 32'h0, 6'd0, 7'd0}},
        '{FN_READ_LAST,  32'h0,        6'd0,  6'd0,  1'b1, '{STAT_RANGE, 32'h0, 6'd0, 7'd0}}
    };

    int phase_cap  [PHASES] = '{1, 0, 127, 64, 5, 64, 0, 64};
    int phase_fill [PHASES] = '{60, 50, 80, 80, 60, 45, 45, 15};

    ordered_array_list_engine_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .element      (element),
        .index        (index),
        .second_index (second_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .value        (value),
        .found_index  (found_index),
        .count        (count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void drop_entry(input int pos);
        int k;
        for (k = pos; k + 1 < list_count; k++)
        begin
            list_words[k] = list_words[k + 1];
        end
        list_count--;
    endfunction

    function automatic result_t list_op_result(input logic [3:0] f, input logic [31:0] e,
                                               input logic [5:0] i, input logic [5:0] j);
        int          lim;
        int          pos;
        int          k;
        logic [31:0] tmp;
        result_t     r;
        r = UNTYPED;
        lim = (cap_limit > DEPTH) ? DEPTH : cap_limit;
        case (f)
            FN_APPEND, FN_INSERT:
            begin
                if (f == FN_INSERT && int'(i) > list_count)
                    r.status = STAT_RANGE;
                else if (list_count >= lim)
                    r.status = STAT_FULL;
                else
                begin
                    pos = (f == FN_APPEND) ? list_count : int'(i);
                    for (k = list_count; k > pos; k--)
                    begin
                        list_words[k] = list_words[k - 1];
                    end
                    list_words[pos] = e;
                    list_count++;
                end
            end
            FN_REPLACE:
            begin
                if (int'(i) >= list_count)
                    r.status = STAT_RANGE;
                else
                begin
                    r.value = list_words[i];
                    list_words[i] = e;
                end
            end
            FN_SWAP:
            begin
                if (int'(i) >= list_count || int'(j) >= list_count)
                    r.status = STAT_RANGE;
                else
                begin
                    tmp = list_words[i];
                    list_words[i] = list_words[j];
                    list_words[j] = tmp;
                end
            end
            FN_READ, FN_REMOVE_AT:
            begin
                if (int'(i) >= list_count)
                    r.status = STAT_RANGE;
                else
                begin
                    r.value = list_words[i];
                    if (f == FN_REMOVE_AT)
                        drop_entry(int'(i));
                end
            end
            FN_READ_LAST, FN_POP:
            begin
                if (list_count == 0)
                    r.status = STAT_RANGE;
                else
                begin
                    r.value = list_words[list_count - 1];
                    if (f == FN_POP)
                        list_count--;
                end
            end
            FN_FIND, FN_REMOVE_VAL:
            begin
                r.status = STAT_NOTFOUND;
                for (k = 0; k < list_count; k++)
                begin
                    if (r.status == STAT_NOTFOUND && list_words[k] == e)
                    begin
                        r.status = STAT_OK;
                        r.found_index = 6'(k);
                    end
                end
                if (r.status == STAT_OK && f == FN_REMOVE_VAL)
                begin
                    r.value = e;
                    drop_entry(int'(r.found_index));
                end
            end
            FN_CLEAR:
                list_count = 0;
            default:
                ;
        endcase
        r.count = 7'(list_count);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR: result %0d: %s", result_seq, msg);
        mismatch_count++;
    endtask

    task automatic check_result();
        result_t want;
        result_seq++;
        if (pending_results.size() == 0)
            report_mismatch("result with no expectation waiting");
        else
        begin
            want = pending_results.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status 0x%0h, expected 0x%0h", status, want.status));
            if (value !== want.value)
                report_mismatch($sformatf("value 0x%0h, expected 0x%0h", value, want.value));
            if (found_index !== want.found_index)
                report_mismatch($sformatf("found_index %0d, expected %0d",
                                          found_index, want.found_index));
            if (count !== want.count)
                report_mismatch($sformatf("count %0d, expected %0d", count, want.count));
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 37);
        if (rst_n && out_valid && out_ready)
            check_result();
    end

    task automatic send_item(input logic [3:0] f, input logic [31:0] e, input logic [5:0] i,
                             input logic [5:0] j, input bit typed, input result_t typed_res);
        int      gap;
        result_t res;
        gap = 0;
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 37)
                gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        element      <= e;
        index        <= i;
        second_index <= j;
        do
            @(posedge clk);
        while (!in_ready);
        res = list_op_result(f, e, i, j);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_capacity(input int cap);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= 7'(cap);
        do
            @(posedge clk);
        while (!cfg_ready);
        cap_limit = cap;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [5:0] pick_index();
        int top;
        top = (list_count > 63) ? 63 : list_count;
        if ($urandom_range(0, 9) == 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, top));
    endfunction

    task automatic send_random(input int fill_pct, input bit allow_clear, output bit counted);
        int          r;
        logic [3:0]  f;
        logic [31:0] e;
        logic [5:0]  i;
        logic [5:0]  j;
        r = $urandom_range(0, 99);
        if (r < 3)
            f = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
        else if (r < 3 + fill_pct)
            f = ($urandom_range(0, 1) != 0) ? FN_INSERT : FN_APPEND;
        else if (r == 99 && allow_clear)
            f = FN_CLEAR;
        else
            f = 4'($urandom_range(FN_REPLACE, FN_POP));
        if (list_count == 0 || $urandom_range(0, 9) < 4)
            e = $urandom();
        else
            e = list_words[$urandom_range(0, list_count - 1)];
        i = pick_index();
        j = pick_index();
        send_item(f, e, i, j, 1'b0, UNTYPED);
        counted = (f <= FN_CLEAR);
    endtask

    initial
    begin
        int n;
        int p;
        int done;
        bit counted;
        foreach (list_words[k])
            list_words[k] = 32'h0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (n = 0; n < DIR_ROWS; n++)
        begin
            send_item(dir_rows[n].f, dir_rows[n].e, dir_rows[n].i, dir_rows[n].j,
                      dir_rows[n].typed, dir_rows[n].res);
        end
        for (p = 0; p < PHASES; p++)
        begin
            set_capacity((phase_cap[p] == 0 && p == 6) ? $urandom_range(1, DEPTH)
                                                       : phase_cap[p]);
            steady = (p == 5);
            done = 0;
            while (done < 125)
            begin
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                send_random(phase_fill[p], (p != 2 && p != 3), counted);
                if (counted)
                    done++;
            end
        end
        steady = 1'b0;
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(2_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
